>>> src/ttpr_pkg.sv
// Shared types, codes and constants of the transposition table probe/record block.
// No dependencies; every other file in src imports this package.
package ttpr_pkg;

  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 15;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] MATE_RST = 15'd10000;
  localparam logic [CFG_W-1:0] WIN_RST  = 15'd9800;
  localparam logic [CFG_W-1:0] BAN_RST  = 15'd9900;

  // command codes
  localparam logic [1:0] CMD_PROBE  = 2'd0;
  localparam logic [1:0] CMD_RECORD = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // bound codes; anything else is exact
  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;

  // config register indexes
  localparam logic [1:0] REG_MATE = 2'd0;
  localparam logic [1:0] REG_WIN  = 2'd1;
  localparam logic [1:0] REG_BAN  = 2'd2;

  // one table entry
  typedef struct packed {
    logic              valid;
    logic [1:0]        bound;
    logic [5:0]        depth;
    logic signed [15:0] score;
    logic [15:0]       move;
    logic [31:0]       lock;
  } entry_t;

  // classified request, as queued between front and back
  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        lock;
    logic [6:0]         ply;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [5:0]         depth;
    logic signed [15:0] drawv;
    logic [1:0]         bound;
    logic signed [15:0] rec_score;  // distance-adjusted, saturated
    logic [15:0]        rec_move;
    logic               rec_skip;   // ban/draw: keep old score, move, lock
  } item_t;

  // back-end status toward the front end
  typedef struct packed {
    logic pop;
    logic sweeping;
  } bstat_t;

endpackage

>>> src/ttpr_queue.sv
// Small request FIFO between front and back ends.
// Depends on ttpr_pkg for depth constants.
module ttpr_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_push,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head
);
  import ttpr_pkg::*;

  logic [W-1:0]      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign can_push  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/ttpr_front.sv
// Front end: accepts requests, precomputes the record score, queues them.
// Depends on ttpr_pkg and ttpr_queue.
module ttpr_front #(
  parameter int unsigned INDEX_BITS = ttpr_pkg::INDEX_BITS_DEF,
  parameter int unsigned QW         = INDEX_BITS + $bits(ttpr_pkg::item_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 req_cmd,
  input  logic [31:0]                req_key,
  input  logic [31:0]                req_lock,
  input  logic [6:0]                 req_dist,
  input  logic [15:0]                req_alpha,
  input  logic [15:0]                req_beta,
  input  logic [5:0]                 req_depth,
  input  logic [15:0]                req_drawv,
  input  logic [1:0]                 req_bound,
  input  logic [15:0]                req_score,
  input  logic [15:0]                req_move,
  input  logic [ttpr_pkg::CFG_W-1:0] win_score,
  input  logic [ttpr_pkg::CFG_W-1:0] ban_score,
  input  ttpr_pkg::bstat_t           bstat,
  output logic                       q_valid,
  output logic [QW-1:0]              q_data
);
  import ttpr_pkg::*;

  item_t              item;
  logic               can_push;
  logic               push;
  logic signed [17:0] svl, win_s, ban_s, draw_s, dist_s, adj;
  logic               gt, lt, no_move;

  assign req_ready = can_push && !bstat.sweeping;
  assign push      = req_valid && req_ready;

  // record classification: mate range, ban/draw skip, distance adjust
  always_comb begin
    svl     = {{2{req_score[15]}}, req_score};
    draw_s  = {{2{req_drawv[15]}}, req_drawv};
    win_s   = {3'b000, win_score};
    ban_s   = {3'b000, ban_score};
    dist_s  = {11'd0, req_dist};
    no_move = (req_move == '0);
    gt      = svl > win_s;
    lt      = svl < -win_s;
    adj     = gt ? svl + dist_s : (lt ? svl - dist_s : svl);

    item.cmd      = req_cmd;
    item.lock     = req_lock;
    item.ply      = req_dist;
    item.alpha    = req_alpha;
    item.beta     = req_beta;
    item.depth    = req_depth;
    item.drawv    = req_drawv;
    item.bound    = req_bound;
    item.rec_move = req_move;
    item.rec_skip = no_move && ((gt && svl <= ban_s) || (lt && svl >= -ban_s) ||
                                (!gt && !lt && svl == draw_s));
    if (adj > 18'sd32767) begin
      item.rec_score = 16'sh7fff;
    end else if (adj < -18'sd32768) begin
      item.rec_score = 16'sh8000;
    end else begin
      item.rec_score = adj[15:0];
    end
  end

  ttpr_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({req_key[INDEX_BITS-1:0], item}),
    .can_push  (can_push),
    .pop       (bstat.pop),
    .not_empty (q_valid),
    .head      (q_data)
  );

endmodule

>>> src/ttpr_back.sv
// Back end: table memory, clearing sweep, probe/record execution, result register.
// Depends on ttpr_pkg.
module ttpr_back #(
  parameter int unsigned INDEX_BITS = ttpr_pkg::INDEX_BITS_DEF,
  parameter int unsigned QW         = INDEX_BITS + $bits(ttpr_pkg::item_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [QW-1:0]              q_data,
  output ttpr_pkg::bstat_t           bstat,
  input  logic [ttpr_pkg::CFG_W-1:0] mate_score,
  input  logic [ttpr_pkg::CFG_W-1:0] win_score,
  input  logic [ttpr_pkg::CFG_W-1:0] ban_score,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       res_hit,
  output logic [15:0]                res_score,
  output logic [15:0]                res_hint
);
  import ttpr_pkg::*;

  localparam int unsigned IW = $bits(item_t);

  typedef enum logic [2:0] {
    S_CLR  = 3'b001,
    S_IDLE = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  item_t               cur_r;
  logic [INDEX_BITS-1:0] idx_r;
  entry_t              rd_r;
  entry_t              mem [2**INDEX_BITS];

  logic                  pop, exec_go;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  entry_t                wr_data;

  logic                  out_valid_r, out_hit_r;
  logic [15:0]           out_score_r, out_hint_r;
  logic                  hit;
  logic [15:0]           score, hint;

  logic signed [17:0] vl, adj, win_s, ban_s, draw_s, dist_s, alpha_s, beta_s;
  logic               match, gt, lt, ok, mate, depth_ok, bound_ok, rec_wr;
  logic [15:0]        miss;

  assign pop            = (state_r == S_IDLE) && q_valid;
  assign exec_go        = (state_r == S_EXEC) && (!out_valid_r || res_ready);
  assign bstat.pop      = pop;
  assign bstat.sweeping = (state_r == S_CLR);

  // probe evaluation and record merge on the entry just read
  always_comb begin
    vl      = {{2{rd_r.score[15]}}, rd_r.score};
    win_s   = {3'b000, win_score};
    ban_s   = {3'b000, ban_score};
    draw_s  = {{2{cur_r.drawv[15]}}, cur_r.drawv};
    dist_s  = {11'd0, cur_r.ply};
    alpha_s = {{2{cur_r.alpha[15]}}, cur_r.alpha};
    beta_s  = {{2{cur_r.beta[15]}}, cur_r.beta};
    miss    = 16'(-$signed({1'b0, mate_score}));

    match = rd_r.valid && (rd_r.lock == cur_r.lock);
    gt    = vl > win_s;
    lt    = vl < -win_s;
    mate  = (gt && vl > ban_s) || (lt && vl < -ban_s);
    if (gt) begin
      ok = vl > ban_s;
    end else if (lt) begin
      ok = vl < -ban_s;
    end else begin
      ok = vl != draw_s;
    end
    adj      = gt ? vl - dist_s : (lt ? vl + dist_s : vl);
    depth_ok = mate || (rd_r.depth >= cur_r.depth);
    case (rd_r.bound)
      BOUND_LOWER: bound_ok = adj >= beta_s;
      BOUND_UPPER: bound_ok = adj <= alpha_s;
      default:     bound_ok = 1'b1;
    endcase

    hit   = (cur_r.cmd == CMD_PROBE) && match && ok && depth_ok && bound_ok;
    score = hit ? adj[15:0] : miss;
    hint  = ((cur_r.cmd == CMD_PROBE) && match) ? rd_r.move : '0;

    // depth-preferred replacement; an empty entry holds depth zero
    rec_wr = (cur_r.cmd == CMD_RECORD) && (cur_r.depth >= rd_r.depth);
  end

  // single write port: sweep or record write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_r;
    if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = '0;
    end else if (exec_go && rec_wr) begin
      wr_en         = 1'b1;
      wr_data.valid = 1'b1;
      wr_data.bound = cur_r.bound;
      wr_data.depth = cur_r.depth;
      if (!cur_r.rec_skip) begin
        wr_data.score = cur_r.rec_score;
        wr_data.move  = cur_r.rec_move;
        wr_data.lock  = cur_r.lock;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          if (cur_r.cmd == CMD_CLEAR) begin
            state_nxt = S_CLR;
            cnt_nxt   = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data[IW-1:0];
      idx_r <= q_data[QW-1 -: INDEX_BITS];
      rd_r  <= mem[q_data[QW-1 -: INDEX_BITS]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (exec_go) begin
      out_hit_r   <= hit;
      out_score_r <= score;
      out_hint_r  <= hint;
    end
  end

  assign res_valid = out_valid_r;
  assign res_hit   = out_hit_r;
  assign res_score = out_score_r;
  assign res_hint  = out_hint_r;

`ifndef NO_ASSERTIONS
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (state_r == S_CLR) && (cnt_r == '0))
    else $error("sweep does not restart after reset");

  a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> wr_en && (wr_data == '0) && !pop)
    else $error("sweep write not zero or request popped during sweep");

  a_non_probe_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && (cur_r.cmd != CMD_PROBE) |=> out_valid_r && !out_hit_r && (out_hint_r == '0))
    else $error("record/clear result carries hit or hint");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_ready |=> out_valid_r && $stable(out_score_r) && $stable(out_hint_r))
    else $error("pending result overwritten");
`endif

endmodule

>>> src/transposition_table_probe_record.sv
// Top level of the direct-mapped transposition table (probe / record / clear).
// Depends on ttpr_pkg, ttpr_front, ttpr_back (and ttpr_queue below the front).
//
// Use:
//   in_*   : request stream. in_tuser carries the command (probe, record, clear),
//            in_tdata the key, lock, ply distance, window, depth, draw value and
//            the record payload. A request is taken when in_tvalid && in_tready.
//   out_*  : one result per request, in request order. out_tuser is the hit flag,
//            out_tdata the score and the hint move. Records and clears return
//            hit 0, score -mate_score, hint 0.
//   cfg_*  : write-only registers mate_score, win_score, ban_score; write while idle.
// Flow: a request accepted into an empty, idle block is queued, then popped while its
//   table entry is read into a register, then evaluated and written back, and its
//   result is registered. The back end takes the next request only when it is idle
//   again. A two-entry request queue lets the input side run ahead of the table.
// Reset and clear: after reset, and after a clear request is executed, the table is
//   swept to zero, one entry per clock; in_tready stays low during the sweep.
//   Config writes are taken at any time.
// Stall: while a result is pending and out_tready is low, the result register holds;
//   the back end stops at its evaluate step and the queue fills, then in_tready drops.
module transposition_table_probe_record #(
  parameter int unsigned INDEX_BITS = ttpr_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [1:0]                 in_tuser,   // command
  // position_key, position_lock, ply_distance, window_low, window_high,
  // search_depth, draw_score, store_bound, store_score, store_move, zero pad
  input  logic [159:0]               in_tdata,
  // result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic                       out_tuser,  // hit
  output logic [31:0]                out_tdata,  // score, hint_move
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ttpr_pkg::CFG_W-1:0] cfg_wdata
);
  import ttpr_pkg::*;

  localparam int unsigned QW = INDEX_BITS + $bits(item_t);

  logic [CFG_W-1:0] mate_r, win_r, ban_r;
  logic             q_valid;
  logic [QW-1:0]    q_data;
  bstat_t           bstat;
  logic             res_hit;
  logic [15:0]      res_score, res_hint;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_r <= MATE_RST;
      win_r  <= WIN_RST;
      ban_r  <= BAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATE: mate_r <= cfg_wdata;
        REG_WIN:  win_r  <= cfg_wdata;
        REG_BAN:  ban_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  ttpr_front #(.INDEX_BITS(INDEX_BITS), .QW(QW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_cmd   (in_tuser),
    .req_key   (in_tdata[31:0]),
    .req_lock  (in_tdata[63:32]),
    .req_dist  (in_tdata[70:64]),
    .req_alpha (in_tdata[86:71]),
    .req_beta  (in_tdata[102:87]),
    .req_depth (in_tdata[108:103]),
    .req_drawv (in_tdata[124:109]),
    .req_bound (in_tdata[126:125]),
    .req_score (in_tdata[142:127]),
    .req_move  (in_tdata[158:143]),
    .win_score (win_r),
    .ban_score (ban_r),
    .bstat     (bstat),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ttpr_back #(.INDEX_BITS(INDEX_BITS), .QW(QW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .bstat      (bstat),
    .mate_score (mate_r),
    .win_score  (win_r),
    .ban_score  (ban_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_hit    (res_hit),
    .res_score  (res_score),
    .res_hint   (res_hint)
  );

  assign out_tuser = res_hit;
  assign out_tdata = {res_hint, res_score};

endmodule
